/* hdl/hsvcc_pkg.sv */
// shared types and constants of the hsv colour class filter
package hsvcc_pkg;

  localparam int CLASS_N = 10;
  localparam int HQ_W    = 5;   // hue quotient, at most 30
  localparam int SQ_W    = 8;   // saturation quotient, at most 255
  localparam int HREM_W  = 13;  // 30 * 255 fits
  localparam int SREM_W  = 16;  // 255 * 255 fits

  // class bit positions
  localparam int CLS_BLACK  = 0;
  localparam int CLS_GRAY   = 1;
  localparam int CLS_WHITE  = 2;
  localparam int CLS_RED    = 3;
  localparam int CLS_ORANGE = 4;
  localparam int CLS_YELLOW = 5;
  localparam int CLS_GREEN  = 6;
  localparam int CLS_CYAN   = 7;
  localparam int CLS_BLUE   = 8;
  localparam int CLS_PURPLE = 9;

  // dominant channel codes
  localparam logic [1:0] SECT_RED   = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE  = 2'd2;

  // hue offsets of each sector, half degrees
  localparam logic [7:0] HUE_GREEN_BASE = 8'd60;
  localparam logic [7:0] HUE_BLUE_BASE  = 8'd120;
  localparam logic [7:0] HUE_WRAP       = 8'd180;

  // class limits, all inclusive
  localparam logic [7:0] V_BLACK_MAX  = 8'd46;
  localparam logic [7:0] S_GRAY_MAX   = 8'd43;
  localparam logic [7:0] V_GRAY_MIN   = 8'd46;
  localparam logic [7:0] V_GRAY_MAX   = 8'd220;
  localparam logic [7:0] S_WHITE_MAX  = 8'd30;
  localparam logic [7:0] V_WHITE_MIN  = 8'd221;
  localparam logic [7:0] S_CHROMA_MIN = 8'd43;
  localparam logic [7:0] V_CHROMA_MIN = 8'd46;

  localparam logic [7:0] H_RED_LO_MAX  = 8'd10;
  localparam logic [7:0] H_RED_HI_MIN  = 8'd156;
  localparam logic [7:0] H_RED_HI_MAX  = 8'd180;
  localparam logic [7:0] H_ORANGE_MIN  = 8'd11;
  localparam logic [7:0] H_ORANGE_MAX  = 8'd25;
  localparam logic [7:0] H_YELLOW_MIN  = 8'd26;
  localparam logic [7:0] H_YELLOW_MAX  = 8'd34;
  localparam logic [7:0] H_GREEN_MIN   = 8'd35;
  localparam logic [7:0] H_GREEN_MAX   = 8'd77;
  localparam logic [7:0] H_CYAN_MIN    = 8'd78;
  localparam logic [7:0] H_CYAN_MAX    = 8'd99;
  localparam logic [7:0] H_BLUE_MIN    = 8'd100;
  localparam logic [7:0] H_BLUE_MAX    = 8'd124;
  localparam logic [7:0] H_PURPLE_MIN  = 8'd125;
  localparam logic [7:0] H_PURPLE_MAX  = 8'd155;

  // register index on the configuration port
  localparam logic REG_COLOUR_SELECT = 1'b0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0]         hue;
    logic [7:0]         saturation;
    logic [7:0]         brightness;
    logic [CLASS_N-1:0] class_hits;
    logic [7:0]         mask;
  } result_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_t;

endpackage

/* hdl/hsv_colour_class_filter.sv */
// top level: rgb to hsv conversion pipeline with colour class tests
// Takes one 8-bit rgb pixel per clock while pixel_stall is low and returns its
// hue (0..179, half degrees), saturation, brightness, ten colour class hit bits
// and a 0/255 mask for the class chosen in colour_select (byte address 0 on the
// apb port; codes above 9 give a zero mask). The pipeline is seven register
// stages deep, and a new pixel is taken every cycle when nothing stalls. The
// depth comes from the two divisions, hue and saturation, which run as restoring
// dividers side by side at up to two quotient bits per stage. Each stage holds
// its item until the next stage is free, so a stall on the result side fills the
// bubbles first and only then pushes back onto pixel_stall.
module hsv_colour_class_filter import hsvcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // pixel in
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  pixel_t      pixel,
  // result out
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // front stage: channel extremes and hue numerator sign
  typedef struct packed {
    logic [7:0] mx;
    logic [7:0] d;
    logic [1:0] sector;
    logic       neg;
    logic [7:0] absdiff;
  } front_t;

  // divider stages: both remainders and partial quotients
  typedef struct packed {
    logic [7:0]        mx;
    logic [7:0]        d;
    logic [1:0]        sector;
    logic              neg;
    logic [HREM_W-1:0] hrem;
    logic [HQ_W-1:0]   hq;
    logic [SREM_W-1:0] srem;
    logic [SQ_W-1:0]   sq;
  } div_t;

  logic [3:0] colour_select;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_select <= 4'd0;
    end else if (psel && penable && pwrite && paddr[2] == REG_COLOUR_SELECT) begin
      colour_select <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == REG_COLOUR_SELECT) ? 32'(colour_select) : 32'd0;

  // ---------------- stage valid bits and flow control ----------------
  // stage 1 front, 2 numerators, 3..5 division, 6 last saturation bits and hue fix-up, 7 output
  logic [7:1] vld;
  logic [7:1] rdy;

  assign rdy[7] = !vld[7] || !result_stall;
  assign rdy[6] = !vld[6] || rdy[7];
  assign rdy[5] = !vld[5] || rdy[6];
  assign rdy[4] = !vld[4] || rdy[5];
  assign rdy[3] = !vld[3] || rdy[4];
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];

  assign pixel_stall  = !rdy[1];
  assign result_valid = vld[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= pixel_valid;
      if (rdy[2]) vld[2] <= vld[1];
      if (rdy[3]) vld[3] <= vld[2];
      if (rdy[4]) vld[4] <= vld[3];
      if (rdy[5]) vld[5] <= vld[4];
      if (rdy[6]) vld[6] <= vld[5];
      if (rdy[7]) vld[7] <= vld[6];
    end
  end

  // ---------------- stage 1: max, min, sector ----------------
  front_t front, front_next;

  always_comb begin
    logic [7:0] mn;
    mn = pixel.red;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn)  mn = pixel.blue;
    front_next.mx = pixel.red;
    if (pixel.green > front_next.mx) front_next.mx = pixel.green;
    if (pixel.blue > front_next.mx)  front_next.mx = pixel.blue;
    front_next.d = front_next.mx - mn;
    // ties go to red first, then green
    if (front_next.mx == pixel.red) begin
      front_next.sector  = SECT_RED;
      front_next.neg     = pixel.green < pixel.blue;
      front_next.absdiff = front_next.neg ? pixel.blue - pixel.green
                                          : pixel.green - pixel.blue;
    end else if (front_next.mx == pixel.green) begin
      front_next.sector  = SECT_GREEN;
      front_next.neg     = pixel.blue < pixel.red;
      front_next.absdiff = front_next.neg ? pixel.red - pixel.blue
                                          : pixel.blue - pixel.red;
    end else begin
      front_next.sector  = SECT_BLUE;
      front_next.neg     = pixel.red < pixel.green;
      front_next.absdiff = front_next.neg ? pixel.green - pixel.red
                                          : pixel.red - pixel.green;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) front <= front_next;
  end

  // ---------------- stage 2: dividends ----------------
  // 30*x as 32x - 2x, 255*d as 256d - d
  div_t num, num_next;

  always_comb begin
    num_next.mx     = front.mx;
    num_next.d      = front.d;
    num_next.sector = front.sector;
    num_next.neg    = front.neg;
    num_next.hrem   = HREM_W'({front.absdiff, 5'b0}) - HREM_W'({front.absdiff, 1'b0});
    num_next.hq     = '0;
    num_next.srem   = {front.d, 8'b0} - SREM_W'(front.d);
    num_next.sq     = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) num <= num_next;
  end

  // ---------------- stages 3..5: division ----------------
  div_t dv3, dv3_next, dv4, dv4_next, dv5, dv5_next;

  // stage 3: hue bits 4..3, saturation bits 7..6
  hsvcc_div_step #(.REM_W(HREM_W), .DEN_W(8), .Q_W(HQ_W), .SHIFT_HI(4), .STEPS(2))
    u_hue_3 (.rem_in(num.hrem), .den(num.d), .q_in(num.hq),
             .rem_out(dv3_next.hrem), .q_out(dv3_next.hq));
  hsvcc_div_step #(.REM_W(SREM_W), .DEN_W(8), .Q_W(SQ_W), .SHIFT_HI(7), .STEPS(2))
    u_sat_3 (.rem_in(num.srem), .den(num.mx), .q_in(num.sq),
             .rem_out(dv3_next.srem), .q_out(dv3_next.sq));
  assign dv3_next.mx     = num.mx;
  assign dv3_next.d      = num.d;
  assign dv3_next.sector = num.sector;
  assign dv3_next.neg    = num.neg;

  always_ff @(posedge clk) begin
    if (rdy[3]) dv3 <= dv3_next;
  end

  // stage 4: hue bits 2..1, saturation bits 5..4
  hsvcc_div_step #(.REM_W(HREM_W), .DEN_W(8), .Q_W(HQ_W), .SHIFT_HI(2), .STEPS(2))
    u_hue_4 (.rem_in(dv3.hrem), .den(dv3.d), .q_in(dv3.hq),
             .rem_out(dv4_next.hrem), .q_out(dv4_next.hq));
  hsvcc_div_step #(.REM_W(SREM_W), .DEN_W(8), .Q_W(SQ_W), .SHIFT_HI(5), .STEPS(2))
    u_sat_4 (.rem_in(dv3.srem), .den(dv3.mx), .q_in(dv3.sq),
             .rem_out(dv4_next.srem), .q_out(dv4_next.sq));
  assign dv4_next.mx     = dv3.mx;
  assign dv4_next.d      = dv3.d;
  assign dv4_next.sector = dv3.sector;
  assign dv4_next.neg    = dv3.neg;

  always_ff @(posedge clk) begin
    if (rdy[4]) dv4 <= dv4_next;
  end

  // stage 5: last hue bit, saturation bits 3..2
  hsvcc_div_step #(.REM_W(HREM_W), .DEN_W(8), .Q_W(HQ_W), .SHIFT_HI(0), .STEPS(1))
    u_hue_5 (.rem_in(dv4.hrem), .den(dv4.d), .q_in(dv4.hq),
             .rem_out(dv5_next.hrem), .q_out(dv5_next.hq));
  hsvcc_div_step #(.REM_W(SREM_W), .DEN_W(8), .Q_W(SQ_W), .SHIFT_HI(3), .STEPS(2))
    u_sat_5 (.rem_in(dv4.srem), .den(dv4.mx), .q_in(dv4.sq),
             .rem_out(dv5_next.srem), .q_out(dv5_next.sq));
  assign dv5_next.mx     = dv4.mx;
  assign dv5_next.d      = dv4.d;
  assign dv5_next.sector = dv4.sector;
  assign dv5_next.neg    = dv4.neg;

  always_ff @(posedge clk) begin
    if (rdy[5]) dv5 <= dv5_next;
  end

  // ---------------- stage 6: last saturation bits, hue fix-up ----------------
  hsv_t hsv, hsv_next;
  logic [SREM_W-1:0] srem_last;
  logic [SQ_W-1:0]   sq_last;

  hsvcc_div_step #(.REM_W(SREM_W), .DEN_W(8), .Q_W(SQ_W), .SHIFT_HI(1), .STEPS(2))
    u_sat_6 (.rem_in(dv5.srem), .den(dv5.mx), .q_in(dv5.sq),
             .rem_out(srem_last), .q_out(sq_last));

  always_comb begin
    logic [7:0] hq_w;
    logic [7:0] adj;
    hq_w = 8'(dv5.hq);
    // floor of a negative quotient rounds away from zero
    adj  = hq_w + 8'(dv5.hrem != '0);
    hsv_next.val = dv5.mx;
    if (dv5.d == 8'd0) begin
      // channels all equal (black, gray or white): no hue, no saturation
      hsv_next.hue = 8'd0;
      hsv_next.sat = 8'd0;
    end else begin
      hsv_next.sat = sq_last;
      case (dv5.sector)
        SECT_RED:   hsv_next.hue = dv5.neg ? HUE_WRAP - adj : hq_w;
        SECT_GREEN: hsv_next.hue = dv5.neg ? HUE_GREEN_BASE - adj : HUE_GREEN_BASE + hq_w;
        SECT_BLUE:  hsv_next.hue = dv5.neg ? HUE_BLUE_BASE - adj : HUE_BLUE_BASE + hq_w;
        default:    hsv_next.hue = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) hsv <= hsv_next;
  end

  // ---------------- stage 7: class tests, output register ----------------
  result_t result_next;

  hsvcc_classify u_classify (
    .hsv (hsv),
    .sel (colour_select),
    .res (result_next)
  );

  always_ff @(posedge clk) begin
    if (rdy[7]) result <= result_next;
  end

endmodule

/* hdl/hsvcc_div_step.sv */
// STEPS restoring division steps, one quotient bit each
module hsvcc_div_step import hsvcc_pkg::*; #(
  parameter int REM_W    = 16,
  parameter int DEN_W    = 8,
  parameter int Q_W      = 8,
  parameter int SHIFT_HI = 7,
  parameter int STEPS    = 2
) (
  input  logic [REM_W-1:0] rem_in,
  input  logic [DEN_W-1:0] den,
  input  logic [Q_W-1:0]   q_in,
  output logic [REM_W-1:0] rem_out,
  output logic [Q_W-1:0]   q_out
);

  localparam int WIDE_W = REM_W + Q_W;

  logic [WIDE_W-1:0] rem;
  logic [WIDE_W-1:0] trial;
  logic [Q_W-1:0]    q;

  always_comb begin
    rem   = WIDE_W'(rem_in);
    q     = q_in;
    trial = '0;
    for (int k = 0; k < STEPS; k++) begin
      trial = WIDE_W'(den) << (SHIFT_HI - k);
      if (rem >= trial) begin
        rem              = rem - trial;
        q[SHIFT_HI - k]  = 1'b1;
      end
    end
    rem_out = rem[REM_W-1:0];
    q_out   = q;
  end

endmodule

/* hdl/hsvcc_classify.sv */
// colour range tests and selected-class mask
module hsvcc_classify import hsvcc_pkg::*; (
  input  hsv_t       hsv,
  input  logic [3:0] sel,
  output result_t    res
);

  logic [CLASS_N-1:0] hits;
  logic [15:0]        hits_wide;
  logic               chroma_ok;

  always_comb begin
    chroma_ok = (hsv.sat >= S_CHROMA_MIN) && (hsv.val >= V_CHROMA_MIN);
    hits = '0;
    hits[CLS_BLACK]  = hsv.val <= V_BLACK_MAX;
    hits[CLS_GRAY]   = (hsv.sat <= S_GRAY_MAX) && (hsv.val inside {[V_GRAY_MIN:V_GRAY_MAX]});
    hits[CLS_WHITE]  = (hsv.sat <= S_WHITE_MAX) && (hsv.val >= V_WHITE_MIN);
    hits[CLS_RED]    = chroma_ok &&
                       (hsv.hue inside {[8'd0:H_RED_LO_MAX], [H_RED_HI_MIN:H_RED_HI_MAX]});
    hits[CLS_ORANGE] = chroma_ok && (hsv.hue inside {[H_ORANGE_MIN:H_ORANGE_MAX]});
    hits[CLS_YELLOW] = chroma_ok && (hsv.hue inside {[H_YELLOW_MIN:H_YELLOW_MAX]});
    hits[CLS_GREEN]  = chroma_ok && (hsv.hue inside {[H_GREEN_MIN:H_GREEN_MAX]});
    hits[CLS_CYAN]   = chroma_ok && (hsv.hue inside {[H_CYAN_MIN:H_CYAN_MAX]});
    hits[CLS_BLUE]   = chroma_ok && (hsv.hue inside {[H_BLUE_MIN:H_BLUE_MAX]});
    hits[CLS_PURPLE] = chroma_ok && (hsv.hue inside {[H_PURPLE_MIN:H_PURPLE_MAX]});
    // selector codes above purple land on the zero padding
    hits_wide = 16'(hits);

    res.hue        = hsv.hue;
    res.saturation = hsv.sat;
    res.brightness = hsv.val;
    res.class_hits = hits;
    res.mask       = hits_wide[sel] ? 8'hFF : 8'h00;
  end

endmodule

/* verif/tb.sv */
// self-checking testbench for the hsv colour class filter
`timescale 1ns / 100ps

module tb;
  import hsvcc_pkg::*;

  localparam int          QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam int          HOLD_CYCLES  = 80;    // long result hold-off, well past pipeline depth
  localparam int          CHUNK_ITEMS  = 288;   // random pixels per phase
  localparam int          SETTLE_WAIT  = 20;    // latency allowance at the end
  localparam logic [7:0]  MASK_ON      = 8'hFF;
  localparam logic [2:0]  ADDR_SELECT  = {REG_COLOUR_SELECT, 2'b00};
  localparam logic [2:0]  ADDR_SPARE   = 3'd4;  // next register slot, nothing lives there

  // hand-picked pixels: extremes, channel ties, class boundaries, hue wrap
  localparam logic [23:0] CORNER_PIXELS [24] = '{
    24'h000000,  // all zero, black
    24'hFFFFFF,  // full white
    24'hFF0000, 24'h00FF00, 24'h0000FF,  // pure primaries
    24'hFFFF00,  // red and green tie, red wins
    24'h00FFFF,  // green and blue tie, green wins
    24'hFF00FF,  // red and blue tie, negative raw hue
    24'hFF0001,  // tiny negative raw hue, wraps to 179
    24'h2E2E2E, 24'h2F2F2F,  // black / gray brightness edge
    24'hDCDCDC, 24'hDDDDDD,  // gray / white brightness edge
    24'h808080,  // mid gray
    24'hFF8000, 24'hFFC800,  // orange
    24'h2E0000,  // chroma brightness floor, also black
    24'h2F1B1B,
    24'hDDC8C8,  // low saturation bright pixel
    24'h8000FF, 24'h0064C8,
    24'h010000,  // smallest non-zero maximum
    24'hFEFFFE, 24'h7F7F80   // near gray, max by one step
  };

  // tracks expected hsv results and checks the ones the block hands back
  class hsv_result_tracker;
    result_t    pending_results [$];
    logic [3:0] colour_sel;
    int         fails;

    function new();
      colour_sel = 4'd0;
      fails      = 0;
    endfunction

    function void flag(string what);
      fails++;
      if (fails <= 10) $display("%0t mismatch: %s", $time, what);
    endfunction

    function int floor_div(int num, int den);
      if (num >= 0) return num / den;
      return -((-num + den - 1) / den);
    endfunction

    function result_t predict_hsv(pixel_t px);
      result_t res;
      int      r, g, b, top, bottom, span, h, s;
      logic    chroma;
      r = px.red;
      g = px.green;
      b = px.blue;
      top    = (r > g) ? r : g;
      top    = (b > top) ? b : top;
      bottom = (r < g) ? r : g;
      bottom = (b < bottom) ? b : bottom;
      span   = top - bottom;
      h = 0;
      // ties: red beats green, green beats blue
      if (span > 0) begin
        if (top == r) begin
          h = floor_div(30 * (g - b), span);
          if (h < 0) h += 180;
        end else if (top == g) begin
          h = 60 + floor_div(30 * (b - r), span);
        end else begin
          h = 120 + floor_div(30 * (r - g), span);
        end
      end
      s = (top > 0) ? (255 * span) / top : 0;
      res.hue        = h[7:0];
      res.saturation = s[7:0];
      res.brightness = top[7:0];
      chroma = (res.saturation >= S_CHROMA_MIN) && (res.brightness >= V_CHROMA_MIN);
      res.class_hits = '0;
      res.class_hits[CLS_BLACK]  = res.brightness <= V_BLACK_MAX;
      res.class_hits[CLS_GRAY]   = (res.saturation <= S_GRAY_MAX) &&
                                   (res.brightness >= V_GRAY_MIN) &&
                                   (res.brightness <= V_GRAY_MAX);
      res.class_hits[CLS_WHITE]  = (res.saturation <= S_WHITE_MAX) &&
                                   (res.brightness >= V_WHITE_MIN);
      res.class_hits[CLS_RED]    = chroma && ((res.hue <= H_RED_LO_MAX) ||
                                   (res.hue >= H_RED_HI_MIN && res.hue <= H_RED_HI_MAX));
      res.class_hits[CLS_ORANGE] = chroma && res.hue >= H_ORANGE_MIN && res.hue <= H_ORANGE_MAX;
      res.class_hits[CLS_YELLOW] = chroma && res.hue >= H_YELLOW_MIN && res.hue <= H_YELLOW_MAX;
      res.class_hits[CLS_GREEN]  = chroma && res.hue >= H_GREEN_MIN && res.hue <= H_GREEN_MAX;
      res.class_hits[CLS_CYAN]   = chroma && res.hue >= H_CYAN_MIN && res.hue <= H_CYAN_MAX;
      res.class_hits[CLS_BLUE]   = chroma && res.hue >= H_BLUE_MIN && res.hue <= H_BLUE_MAX;
      res.class_hits[CLS_PURPLE] = chroma && res.hue >= H_PURPLE_MIN && res.hue <= H_PURPLE_MAX;
      // selector codes past the last class never light the mask
      res.mask = (colour_sel < CLASS_N && res.class_hits[colour_sel]) ? MASK_ON : 8'd0;
      return res;
    endfunction

    function void note_pixel(pixel_t px);
      pending_results.push_back(predict_hsv(px));
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) flag($sformatf("%s expected %0d, got %0d", name, want, got));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        flag("result with no pixel outstanding");
        return;
      end
      want = pending_results.pop_front();
      compare_field("hue", want.hue, got.hue);
      compare_field("saturation", want.saturation, got.saturation);
      compare_field("brightness", want.brightness, got.brightness);
      compare_field("class_hits", want.class_hits, got.class_hits);
      compare_field("mask", want.mask, got.mask);
    endfunction
  endclass

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        pixel_valid  = 1'b0;
  logic        pixel_stall;
  pixel_t      pixel        = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  hsv_result_tracker tracker = new();

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off_req  = 1'b0;

  hsv_colour_class_filter i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // both handshakes are observed here on the rising edge; the prediction is
  // taken with the select value in force, which only moves while idle
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && !pixel_stall) tracker.note_pixel(pixel);
      if (result_valid && !result_stall) tracker.check_result(result);
    end
  end

  // result side back-pressure: random stalls, or one long hold-off on request
  // so the pipeline fills and pushes back onto the pixel side
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        result_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // gives up once nothing has moved on any port for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || psel || (pixel_valid && !pixel_stall) || (result_valid && !result_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // all tasks below start and end just after a falling edge

  task automatic drive_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= px;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    pixel_valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // writes an address, then reads the select register back against our copy
  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] rdata;
    apb_access(1'b1, addr, data, rdata);
    if (addr == ADDR_SELECT) tracker.colour_sel = data[3:0];
    apb_access(1'b0, ADDR_SELECT, '0, rdata);
    tracker.compare_field("colour_select readback", tracker.colour_sel, rdata[3:0]);
  endtask

  function automatic logic [7:0] corner_level();
    case ($urandom_range(3))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // half uniform colour, the other half grays, channel ties,
  // washed-out pixels and extreme channel values
  function automatic pixel_t random_pixel();
    pixel_t      px;
    logic [7:0]  level;
    int          base;
    level = 8'($urandom_range(255));
    base  = $urandom_range(235);
    px    = {8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255))};
    case ($urandom_range(11))
      0: px = {level, level, level};
      1: px = {level, level, 8'($urandom_range(level))};
      2: px = {8'($urandom_range(level)), level, level};
      3: px = {level, 8'($urandom_range(level)), level};
      4: px = {8'(base + $urandom_range(20)), 8'(base + $urandom_range(20)),
               8'(base + $urandom_range(20))};
      5: px = {corner_level(), corner_level(), corner_level()};
      default: ;
    endcase
    return px;
  endfunction

  task automatic run_phase(input logic [31:0] sel, input int send_pct, input int recv_pct,
                           input bit hold_off);
    write_register(ADDR_SELECT, sel);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    hold_off_req  = hold_off;
    repeat (CHUNK_ITEMS) drive_pixel(random_pixel());
    drain_results();
  endtask

  initial begin : stimulus
    logic [31:0] rdata;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset value of the select register, then the hand-picked pixels
    apb_access(1'b0, ADDR_SELECT, '0, rdata);
    tracker.compare_field("colour_select after reset", 0, rdata[3:0]);
    foreach (CORNER_PIXELS[i]) drive_pixel(pixel_t'(CORNER_PIXELS[i]));
    drain_results();

    // sender sparse, receiver stalling heavily; upper data bits carry junk
    run_phase({28'hFFFFFFF, 4'd9}, 28, 67, 1'b0);
    write_register(ADDR_SPARE, $urandom);  // must not touch the select
    run_phase(32'd0, 28, 67, 1'b0);
    // the other way round, including out-of-range selects
    run_phase(32'd15, 67, 28, 1'b0);
    run_phase(32'd6, 67, 28, 1'b0);
    // full rate, first with a long hold-off on the result side
    run_phase(32'd3, 0, 0, 1'b1);
    run_phase($urandom_range(15), 0, 0, 1'b0);

    repeat (SETTLE_WAIT) @(negedge clk);
    if (tracker.pending_results.size() != 0) tracker.flag("results never arrived");
    if (tracker.fails == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
